@@ src/rpmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_pkg: shared types and constants
// Field widths, register codes, controller states, command/status bundles and
// the red-to-weight table of the red pixel mask and centroid unit.
// ----------------------------------------------------------------------------
package rpmc_pkg;

  localparam int PIX_W       = 16;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 10;
  localparam int WGT_W       = 10;
  localparam int PRODX_W     = COL_W + WGT_W;
  localparam int PRODY_W     = ROW_W + WGT_W;
  localparam int SUM_W       = 40;
  localparam int WSUM_W      = 26;
  localparam int CX_W        = 9;
  localparam int CY_W        = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int DIV_CNT_W   = 6;

  localparam int LINE_WIDTH_DEF = 320;
  localparam int MAX_ROWS_DEF   = 1024;

  localparam logic [PIX_W-1:0] RED_MASK   = 16'hF800;
  localparam logic [PIX_W-1:0] GREEN_MASK = 16'h07E0;
  localparam logic [PIX_W-1:0] BLUE_MASK  = 16'h001F;

  localparam logic [CFG_W-1:0] RED_MIN_RST   = 16'd0;
  localparam logic [CFG_W-1:0] GREEN_MAX_RST = 16'd2016;
  localparam logic [CFG_W-1:0] BLUE_MAX_RST  = 16'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_MIN   = 2'd0,
    CFG_GREEN_MAX = 2'd1,
    CFG_BLUE_MAX  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LDX,
    S_DIVX,
    S_LDY,
    S_DIVY,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_sel_y;
    logic div_step;
    logic cap_x;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_last;
    logic weight_zero;
    logic out_free;
  } dp_stat_t;

  // floor((red5 << 11) / 100) for each 5-bit red code
  localparam logic [WGT_W-1:0] WEIGHT_LUT [32] = '{
    10'd0,   10'd20,  10'd40,  10'd61,  10'd81,  10'd102, 10'd122, 10'd143,
    10'd163, 10'd184, 10'd204, 10'd225, 10'd245, 10'd266, 10'd286, 10'd307,
    10'd327, 10'd348, 10'd368, 10'd389, 10'd409, 10'd430, 10'd450, 10'd471,
    10'd491, 10'd512, 10'd532, 10'd552, 10'd573, 10'd593, 10'd614, 10'd634
  };

endpackage
`default_nettype wire

@@ src/rpmc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_ctrl: sequencing controller
// Takes pixel requests, and on a frame end runs the accumulate, the two
// divisions (skipped when the frame weight is zero) and the result load.
// ----------------------------------------------------------------------------
module rpmc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire rpmc_pkg::dp_stat_t stat,
  output rpmc_pkg::dp_cmd_t       cmd
);
  import rpmc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && stat.out_free && stat.in_last) state_nxt = S_ACC;
      end
      S_ACC: state_nxt = S_LDX;
      S_LDX: begin
        cnt_nxt   = '0;
        state_nxt = stat.weight_zero ? S_RESULT : S_DIVX;
      end
      S_DIVX: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_LDY;
      end
      S_LDY: begin
        cnt_nxt   = '0;
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready       = (state_r == S_IDLE) && stat.out_free;
    cmd             = '0;
    cmd.accept      = in_tvalid && in_tready;
    cmd.div_load    = (state_r == S_LDX) || (state_r == S_LDY);
    cmd.div_sel_y   = (state_r == S_LDY);
    cmd.div_step    = (state_r == S_DIVX) || (state_r == S_DIVY);
    cmd.cap_x       = (state_r == S_LDY);
    cmd.result_load = (state_r == S_RESULT) && stat.out_free;
  end

endmodule
`default_nettype wire

@@ src/rpmc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_dp: datapath
// Threshold mask, position counters, weighted sums, shared restoring divider,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module rpmc_dp #(
  parameter int unsigned LINE_WIDTH = rpmc_pkg::LINE_WIDTH_DEF,
  parameter int unsigned MAX_ROWS   = rpmc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [rpmc_pkg::PIX_W-1:0]        in_tdata,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [rpmc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpmc_pkg::CFG_W-1:0]        cfg_data,
  input  wire rpmc_pkg::dp_cmd_t                 cmd,
  output rpmc_pkg::dp_stat_t                     stat
);
  import rpmc_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  // configuration
  logic [CFG_W-1:0] red_min_r, green_max_r, blue_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_min_r   <= RED_MIN_RST;
      green_max_r <= GREEN_MAX_RST;
      blue_max_r  <= BLUE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RED_MIN:   red_min_r   <= cfg_data;
        CFG_GREEN_MAX: green_max_r <= cfg_data;
        CFG_BLUE_MAX:  blue_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // threshold and weight
  logic             kept;
  logic [PIX_W-1:0] pix_kept;
  logic [WGT_W-1:0] w_kept;

  always_comb begin
    kept = ((in_tdata & GREEN_MASK) <= green_max_r) &&
           ((in_tdata & BLUE_MASK)  <= blue_max_r)  &&
           ((in_tdata & RED_MASK)   >= red_min_r);
    pix_kept = kept ? in_tdata : '0;
    w_kept   = kept ? WEIGHT_LUT[in_tdata[PIX_W-1 -: 5]] : '0;
  end

  // position counters
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (in_tlast) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_r == COL_LAST) begin
        col_r <= '0;
        row_r <= (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // product stage
  logic               pvalid_r;
  logic [PRODX_W-1:0] prod_x_r;
  logic [PRODY_W-1:0] prod_y_r;
  logic [WGT_W-1:0]   wgt_r;
  logic [PIX_W-1:0]   last_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pvalid_r <= 1'b0;
    else        pvalid_r <= cmd.accept;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_x_r <= PRODX_W'(col_r) * PRODX_W'(w_kept);
      prod_y_r <= PRODY_W'(row_r) * PRODY_W'(w_kept);
      wgt_r    <= w_kept;
      if (in_tlast) last_pix_r <= pix_kept;
    end
  end

  // saturating accumulators
  logic [SUM_W-1:0]  xsum_r, ysum_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [SUM_W:0]    xsum_add, ysum_add;
  logic [WSUM_W:0]   wsum_add;

  always_comb begin
    xsum_add = {1'b0, xsum_r} + (SUM_W+1)'(prod_x_r);
    ysum_add = {1'b0, ysum_r} + (SUM_W+1)'(prod_y_r);
    wsum_add = {1'b0, wsum_r} + (WSUM_W+1)'(wgt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.result_load) begin
      xsum_r <= '0;
      ysum_r <= '0;
      wsum_r <= '0;
    end else if (pvalid_r) begin
      xsum_r <= xsum_add[SUM_W]  ? '1 : xsum_add[SUM_W-1:0];
      ysum_r <= ysum_add[SUM_W]  ? '1 : ysum_add[SUM_W-1:0];
      wsum_r <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
    end
  end

  // restoring divider, one quotient bit per cycle; quotient shifts into num_q_r
  logic [SUM_W-1:0]  num_q_r;
  logic [WSUM_W-1:0] rem_r;
  logic [CX_W-1:0]   cx_r;
  logic [WSUM_W:0]   rem_sh;
  logic              rem_ge;
  logic [CX_W-1:0]   q_sat_x;
  logic [CY_W-1:0]   q_sat_y;

  always_comb begin
    rem_sh  = {rem_r, num_q_r[SUM_W-1]};
    rem_ge  = rem_sh >= {1'b0, wsum_r};
    q_sat_x = (|num_q_r[SUM_W-1:CX_W]) ? '1 : num_q_r[CX_W-1:0];
    q_sat_y = (|num_q_r[SUM_W-1:CY_W]) ? '1 : num_q_r[CY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_x) cx_r <= q_sat_x;
    if (cmd.div_load) begin
      num_q_r <= cmd.div_sel_y ? ysum_r : xsum_r;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      num_q_r <= {num_q_r[SUM_W-2:0], rem_ge};
      rem_r   <= rem_ge ? WSUM_W'(rem_sh - {1'b0, wsum_r}) : rem_sh[WSUM_W-1:0];
    end
  end

  // output register
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;
  logic [CX_W-1:0]   out_cx_r;
  logic [CY_W-1:0]   out_cy_r;
  logic [WSUM_W-1:0] out_w_r;
  logic              out_nt_r;
  logic              weight_zero;
  logic              out_load;

  assign weight_zero = (wsum_r == '0);
  assign out_load    = (cmd.accept && !in_tlast) || cmd.result_load;

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (out_load)   out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_pix_r  <= last_pix_r;
      out_last_r <= 1'b1;
      out_cx_r   <= weight_zero ? '0 : cx_r;
      out_cy_r   <= weight_zero ? '0 : q_sat_y;
      out_w_r    <= wsum_r;
      out_nt_r   <= weight_zero;
    end else if (cmd.accept && !in_tlast) begin
      out_pix_r  <= pix_kept;
      out_last_r <= 1'b0;
      out_cx_r   <= '0;
      out_cy_r   <= '0;
      out_w_r    <= '0;
      out_nt_r   <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_nt_r;
  assign out_tdata  = {(OUT_TDATA_W-PIX_W-CX_W-CY_W-WSUM_W)'(0),
                       out_w_r, out_cy_r, out_cx_r, out_pix_r};

  assign stat.in_last     = in_tlast;
  assign stat.weight_zero = weight_zero;
  assign stat.out_free    = !out_valid_r || out_tready;

endmodule
`default_nettype wire

@@ src/red_pixel_mask_and_centroid_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_pixel_mask_and_centroid_unit: red pixel mask with weighted centroid
//
// Input stream in_*: one RGB565 pixel per request in raster order, in_tdata
// holds the pixel and in_tlast marks the last pixel of a frame. Each pixel is
// compared in place against red_min, green_max and blue_max; a rejected pixel
// comes out black. A kept pixel adds column*w, row*w and w to saturating sums,
// with w = floor(masked_red / 100) from a 32-entry table.
// Output stream out_*: one request per pixel, in order. Ordinary pixels are
// accepted one per cycle while the output register is free and show up on
// out_* in the cycle after acceptance. The frame's last pixel carries the
// centroid (out_tlast high), which a restoring divider shared by x and y
// produces one quotient bit per cycle, first for x and then for y; when the
// frame weight is zero both divisions are skipped and out_tuser flags no
// target. in_tready stays low meanwhile.
// Configuration: cfg_* writes are registered; cfg_index 0 red_min,
// 1 green_max, 2 blue_max. Write only while idle.
// Reset (rst_n low, synchronous) clears the sums, the counters and the
// output valid flag, and restores the threshold defaults.
// A stalled receiver holds the output request; a new pixel is taken only
// when the output register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module red_pixel_mask_and_centroid_unit #(
  parameter int unsigned LINE_WIDTH = rpmc_pkg::LINE_WIDTH_DEF,
  parameter int unsigned MAX_ROWS   = rpmc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // pixel input
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rpmc_pkg::PIX_W-1:0]     in_tdata,   // [15:0] pixel_in
  input  wire logic                           in_tlast,   // frame_end
  // result output
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [15:0] pixel_out, [24:16] center_x, [34:25] center_y,
  // [60:35] weight_total, [63:61] zero
  output logic [rpmc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,  // centroid_done
  output logic                                out_tuser,  // [0] no_target
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rpmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rpmc_pkg::CFG_W-1:0]     cfg_data
);
  import rpmc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence pixels, divisions and the frame result
  rpmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // mask, accumulate, divide, hold the result
  rpmc_dp #(
    .LINE_WIDTH (LINE_WIDTH),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
`default_nettype wire

@@ src/rpmc_sva.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_sva: port checker
// Watches the top level's ports for output hold, result field and frame-end
// sequencing rules.
// ----------------------------------------------------------------------------
module rpmc_sva (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           in_tlast,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [rpmc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                           out_tlast,
  input wire logic                           out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  // no-target flag only on a frame result
  a_nt_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("no_target set on a non-final pixel");

  // ordinary pixels carry zero centroid fields
  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[63:16] == 48'd0)
    else $error("centroid fields set on a non-final pixel");

  // no target means zero centroid and weight
  a_nt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:16] == 48'd0)
    else $error("no_target result with nonzero fields");

  // the frame's last pixel starts the result sequence, so input pauses
  a_end_pause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after frame end");

endmodule

bind red_pixel_mask_and_centroid_unit rpmc_sva u_rpmc_sva (.*);
`default_nettype wire
